// ===== src/assert_macros.svh =====
// Assertion macros shared by the glyph address lookup RTL.
// Users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock, off during reset.
`define GAL_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent this cycle implies consequent on the next cycle.
`define GAL_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/gal_pkg.sv =====
// Types and constants for the glyph address lookup block.
// No dependencies; used by gal_cfg, gal_cell and glyph_address_lookup.
package gal_pkg;

	localparam int CODE_W = 16;
	localparam int IDX_W  = 8;
	localparam int ADDR_W = 30;

	// item function codes (s_tuser)
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_WIDE   = 2'd1;
	localparam logic [1:0] FUNC_NARROW = 2'd2;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_BLOCK_COUNT   = 3'd0;
	localparam logic [2:0] REG_WIDE_REPLACE  = 3'd1;
	localparam logic [2:0] REG_NARROW_REPLACE = 3'd2;
	localparam logic [2:0] REG_WIDE_WIDTH    = 3'd3;
	localparam logic [2:0] REG_WIDE_HEIGHT   = 3'd4;
	localparam logic [2:0] REG_NARROW_WIDTH  = 3'd5;
	localparam logic [2:0] REG_NARROW_HEIGHT = 3'd6;

	localparam logic [7:0]  RST_BLOCK_COUNT    = 8'd0;
	localparam logic [15:0] RST_WIDE_REPLACE   = 16'd33088;
	localparam logic [6:0]  RST_NARROW_REPLACE = 7'd63;
	localparam logic [7:0]  RST_WIDE_WIDTH     = 8'd16;
	localparam logic [7:0]  RST_WIDE_HEIGHT    = 8'd16;
	localparam logic [7:0]  RST_NARROW_WIDTH   = 8'd8;
	localparam logic [7:0]  RST_NARROW_HEIGHT  = 8'd16;

	// header sizes of the font image
	localparam logic [10:0] WIDE_HDR   = 11'd18;
	localparam logic [10:0] NARROW_HDR = 11'd17;

	typedef struct packed {
		logic [7:0]  block_count;
		logic [15:0] wide_replace;
		logic [6:0]  narrow_replace;
		logic [7:0]  wide_width;
		logic [7:0]  wide_height;
		logic [7:0]  narrow_width;
		logic [7:0]  narrow_height;
	} cfg_t;

	// table write broadcast to every cell
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] first;
		logic [CODE_W-1:0] last;
	} load_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [CODE_W-1:0] first;
		logic [CODE_W-1:0] base;
	} token_t;

endpackage

// ===== src/gal_cfg.sv =====
// APB register file holding the lookup configuration.
// Depends on gal_pkg.
module gal_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output gal_pkg::cfg_t     cfg
);

	gal_pkg::cfg_t cfg_q;
	logic          wr;
	logic [2:0]    ridx;

	assign wr   = psel & penable & pwrite;
	assign ridx = paddr[4:2];
	assign cfg  = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_count    <= gal_pkg::RST_BLOCK_COUNT;
			cfg_q.wide_replace   <= gal_pkg::RST_WIDE_REPLACE;
			cfg_q.narrow_replace <= gal_pkg::RST_NARROW_REPLACE;
			cfg_q.wide_width     <= gal_pkg::RST_WIDE_WIDTH;
			cfg_q.wide_height    <= gal_pkg::RST_WIDE_HEIGHT;
			cfg_q.narrow_width   <= gal_pkg::RST_NARROW_WIDTH;
			cfg_q.narrow_height  <= gal_pkg::RST_NARROW_HEIGHT;
		end else if (wr) begin
			unique case (ridx)
				gal_pkg::REG_BLOCK_COUNT:    cfg_q.block_count    <= pwdata[7:0];
				gal_pkg::REG_WIDE_REPLACE:   cfg_q.wide_replace   <= pwdata[15:0];
				gal_pkg::REG_NARROW_REPLACE: cfg_q.narrow_replace <= pwdata[6:0];
				gal_pkg::REG_WIDE_WIDTH:     cfg_q.wide_width     <= pwdata[7:0];
				gal_pkg::REG_WIDE_HEIGHT:    cfg_q.wide_height    <= pwdata[7:0];
				gal_pkg::REG_NARROW_WIDTH:   cfg_q.narrow_width   <= pwdata[7:0];
				gal_pkg::REG_NARROW_HEIGHT:  cfg_q.narrow_height  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			gal_pkg::REG_BLOCK_COUNT:    prdata = {24'd0, cfg_q.block_count};
			gal_pkg::REG_WIDE_REPLACE:   prdata = {16'd0, cfg_q.wide_replace};
			gal_pkg::REG_NARROW_REPLACE: prdata = {25'd0, cfg_q.narrow_replace};
			gal_pkg::REG_WIDE_WIDTH:     prdata = {24'd0, cfg_q.wide_width};
			gal_pkg::REG_WIDE_HEIGHT:    prdata = {24'd0, cfg_q.wide_height};
			gal_pkg::REG_NARROW_WIDTH:   prdata = {24'd0, cfg_q.narrow_width};
			gal_pkg::REG_NARROW_HEIGHT:  prdata = {24'd0, cfg_q.narrow_height};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/gal_cell.sv =====
// One cell of the block table: holds one code block entry and checks the
// search token passing through. Depends on gal_pkg.
module gal_cell #(
	parameter int IDX = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gal_pkg::load_t                 load,
	input  logic [gal_pkg::CODE_W-1:0]     code,
	input  logic [gal_pkg::IDX_W-1:0]      count,
	input  logic [gal_pkg::CODE_W-1:0]     prev_base,
	input  gal_pkg::token_t                tok_in,
	output gal_pkg::token_t                tok_out,
	output logic [gal_pkg::CODE_W-1:0]     nxt_base
);

	logic [gal_pkg::CODE_W-1:0] ent_first_q, ent_last_q, ent_base_q;
	logic                       tk_vld_q, tk_found_q;
	logic [gal_pkg::CODE_W-1:0] tk_first_q, tk_base_q;
	logic                       searched, hit;

	// base handed to the next entry: glyphs held up to and including this one
	assign nxt_base = ent_base_q + ent_last_q - ent_first_q + 16'd1;

	assign searched = 9'(IDX) < {1'b0, count};
	assign hit = tok_in.valid && !tok_in.found && searched
		&& (ent_first_q <= code) && (ent_last_q >= code);

	always_ff @(posedge clk) begin
		if (load.en && load.idx == 8'(IDX)) begin
			ent_first_q <= load.first;
			ent_last_q  <= load.last;
			ent_base_q  <= prev_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk_vld_q <= 1'b0;
		end else begin
			tk_vld_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			tk_found_q <= 1'b1;
			tk_first_q <= ent_first_q;
			tk_base_q  <= ent_base_q;
		end else begin
			tk_found_q <= tok_in.found;
			tk_first_q <= tok_in.first;
			tk_base_q  <= tok_in.base;
		end
	end

	assign tok_out = '{valid: tk_vld_q, found: tk_found_q, first: tk_first_q, base: tk_base_q};

endmodule

// ===== src/glyph_address_lookup.sv =====
// Glyph address lookup top level: stream ports, sequencer, address math.
// Depends on gal_pkg, gal_cfg, gal_cell and assert_macros.svh.
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid/s_tready       tuser=func, tdata=index/first/last/code
//  m_*       out  m_tvalid/m_tready       tdata=glyph_address, tuser=flags
//  p*        in   psel&penable&pwrite     APB config, 7 registers at 4*i
//
// Load: writes the cell at block_index directly.
// Double-byte lookup: the token walks the cell chain, and walks it a second
// time with the replacement code when the first pass finds no block.
// Single-byte: multiply, then done. Reset clears control only; table is undefined.
// A finished result sits in the output register; the next item is taken
// while it waits, a second result waits until it is taken.
`include "assert_macros.svh"

module glyph_address_lookup #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // block_index[7:0] block_first[23:8] block_last[39:24] char_code[55:40]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // glyph_address[29:0], zero pad
	output logic [1:0]  m_tuser,   // was_replaced[0] not_found[1]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	gal_pkg::cfg_t   cfg;
	gal_pkg::load_t  load;
	gal_pkg::token_t tok [0:MAX_BLOCKS];
	logic [gal_pkg::CODE_W-1:0] nxt [0:MAX_BLOCKS-1];
	logic [MAX_BLOCKS-1:0] tok_vld;

	logic [1:0]  state_q;
	logic        start_q, replaced_q, missing_q;
	logic [15:0] code_q;
	logic [16:0] slot_q;
	logic [12:0] size_q;
	logic [10:0] offset_q;
	logic [29:0] prod_q;
	logic        m_vld_q, m_rep_q, m_miss_q;
	logic [29:0] m_addr_q;

	logic        take, out_free, tok_end_vld;
	logic [1:0]  func;
	logic [15:0] char_code;
	logic [12:0] wide_size, narrow_size;
	logic [6:0]  narrow_code;
	gal_pkg::token_t tok_end;

	gal_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	assign s_tready  = (state_q == ST_IDLE);
	assign take      = s_tvalid & s_tready;
	assign func      = s_tuser;
	assign char_code = s_tdata[55:40];

	assign load.en    = take && func == gal_pkg::FUNC_LOAD;
	assign load.idx   = s_tdata[7:0];
	assign load.first = s_tdata[23:8];
	assign load.last  = s_tdata[39:24];

	assign wide_size   = 13'(cfg.wide_width[7:3]) * 13'(cfg.wide_height);
	assign narrow_size = 13'(cfg.narrow_width[7:3]) * 13'(cfg.narrow_height);
	assign narrow_code = char_code[7] ? cfg.narrow_replace : char_code[6:0];

	// token enters cell 0 in the cycle in which the code register holds the new code
	assign tok[0]   = '{valid: start_q, found: 1'b0, first: '0, base: '0};
	assign nxt[0]   = '0;
	assign tok_end  = tok[MAX_BLOCKS];
	assign tok_end_vld = tok_end.valid;

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		logic [gal_pkg::CODE_W-1:0] nb;
		gal_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load),
			.code      (code_q),
			.count     (cfg.block_count),
			.prev_base (nxt[i]),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1]),
			.nxt_base  (nb)
		);
		if (i < MAX_BLOCKS - 1) begin : g_link
			assign nxt[i+1] = nb;
		end
		assign tok_vld[i] = tok[i+1].valid;
	end

	assign out_free = !m_vld_q || m_tready;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			m_vld_q <= 1'b0;
		end else begin
			// a search starts on a double-byte item or after a first-pass miss
			start_q <= (state_q == ST_IDLE && take && func == gal_pkg::FUNC_WIDE)
				|| (state_q == ST_SCAN && tok_end_vld && !tok_end.found && !replaced_q);
			if (state_q == ST_DONE && out_free) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take && func == gal_pkg::FUNC_WIDE) begin
						state_q <= ST_SCAN;
					end else if (take && func == gal_pkg::FUNC_NARROW) begin
						state_q <= ST_MUL;
					end
				end
				ST_SCAN: begin
					if (tok_end_vld) begin
						if (tok_end.found) begin
							state_q <= ST_MUL;
						end else if (replaced_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take && func == gal_pkg::FUNC_WIDE) begin
					code_q     <= char_code;
					replaced_q <= 1'b0;
					missing_q  <= 1'b0;
					size_q     <= wide_size;
					offset_q   <= gal_pkg::WIDE_HDR + 11'({cfg.block_count, 2'b00});
				end else if (take && func == gal_pkg::FUNC_NARROW) begin
					slot_q     <= 17'(narrow_code);
					replaced_q <= char_code[7];
					missing_q  <= 1'b0;
					size_q     <= narrow_size;
					offset_q   <= gal_pkg::NARROW_HDR;
				end
			end
			ST_SCAN: begin
				if (tok_end_vld) begin
					if (tok_end.found) begin
						slot_q <= {1'b0, tok_end.base} + {1'b0, code_q - tok_end.first};
					end else if (!replaced_q) begin
						code_q     <= cfg.wide_replace;
						replaced_q <= 1'b1;
					end else begin
						missing_q <= 1'b1;
					end
				end
			end
			ST_MUL: prod_q <= 30'(slot_q * 30'(size_q));
			ST_DONE: begin
				if (out_free) begin
					m_addr_q <= missing_q ? '0 : prod_q + 30'(offset_q);
					m_rep_q  <= replaced_q;
					m_miss_q <= missing_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {2'b00, m_addr_q};
	assign m_tuser  = {m_miss_q, m_rep_q};

	`GAL_ASSERT(a_one_token, $countones({tok_vld, start_q}) <= 1, "more than one search token")
	`GAL_ASSERT(a_token_in_scan, (|tok_vld) |-> state_q == ST_SCAN, "token outside scan")
	`GAL_ASSERT_NEXT(a_scan_hold, state_q == ST_SCAN && !tok_end_vld, state_q == ST_SCAN, "scan left early")
	`GAL_ASSERT(a_miss_zero, (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tdata == 32'd0), "bad miss result")

endmodule
